FILE: src/matrix_coef_slot_interpolator_macros.svh
// Assertion macros for the slot interpolator checker.
// Used by mcsi_chk.sv; no other dependencies.
`ifndef MATRIX_COEF_SLOT_INTERPOLATOR_MACROS_SVH
`define MATRIX_COEF_SLOT_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MCSI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcsi assertion failed");

// Next-cycle implication, disabled during reset
`define MCSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcsi assertion failed");

`endif

FILE: src/mcsi_pkg.sv
// Shared types and constants for the slot interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcsi_pkg;

   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 7;
   localparam int INV_W       = 31;
   localparam int INDEX_W     = 6;
   localparam int PROD_W      = 64;
   localparam int Q_SHIFT     = 30;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 40;

   localparam logic [VALUE_W-1:0] ONE_Q30 = 32'h4000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_EMIT,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               last;
      logic               error;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: src/matrix_coef_slot_interpolator.sv
// Top level of the upmix coefficient slot interpolator: ports and output register.
// Depends on mcsi_pkg, mcsi_seq (which holds mcsi_mul).
//
//  channel | dir | handshake             | contents
//  --------+-----+-----------------------+---------------------------------------------
//  req     | in  | req_tvalid/req_tready | tuser first; tdata anchor, target, count, inv
//  rsp     | out | rsp_tvalid/rsp_tready | tdata value, slot index; tlast; tuser error
//
// Each slot runs three steps on the one shared 32x32 multiplier: prev*(1-alpha),
// alpha*target, then the sum goes to the output register. An item with N slots keeps
// the block busy until its last slot is pushed, a rejected item until its error is
// pushed; a zero-slot item leaves it idle. A full output register stalls both pushes.
// Synchronous reset empties the output and clears start value and slot counter to zero.
`default_nettype none

module matrix_coef_slot_interpolator
   import mcsi_pkg::*;
#(
   parameter int SLOT_CAPACITY = 64
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request side
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [31:0] anchor_value, [63:32] target_value, [70:64] slot_count,
   // [101:71] inv_slot_q30, [103:102] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] first
   input  wire logic                   req_tuser,
   // result side
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] interp_value, [37:32] slot_index, [39:38] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,
   // [0] error
   output logic                        rsp_tuser
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   rsp_item_type seq_item;
   logic         seq_push;
   logic         out_ready;

   // the output register can take a new slot when empty or being drained
   assign out_ready = !rsp_valid_ff || rsp_tready;

   mcsi_seq #(
      .SLOT_CAPACITY (SLOT_CAPACITY)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .first        (req_tuser),
      .anchor_value (req_tdata[31:0]),
      .target_value (req_tdata[63:32]),
      .slot_count   (req_tdata[70:64]),
      .inv_slot_q30 (req_tdata[101:71]),
      .out_ready    (out_ready),
      .out_push     (seq_push),
      .out_item     (seq_item)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (seq_push) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = seq_item;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.index, rsp_item_ff.value};
   assign rsp_tlast  = rsp_item_ff.last;
   assign rsp_tuser  = rsp_item_ff.error;

endmodule

`default_nettype wire

FILE: src/mcsi_mul.sv
// Shared signed 32x32 multiplier with registered 64-bit product.
// Depends on mcsi_pkg.
`default_nettype none

module mcsi_mul
   import mcsi_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic signed [VALUE_W-1:0] op_a,
   input  wire logic signed [VALUE_W-1:0] op_b,
   output logic signed [PROD_W-1:0]       prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

FILE: src/mcsi_seq.sv
// Sequencer: capacity check, run state and per-slot schedule of the shared multiplier.
// Depends on mcsi_pkg and mcsi_mul.
`default_nettype none

module mcsi_seq
   import mcsi_pkg::*;
#(
   parameter int SLOT_CAPACITY = 64
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic               first,
   input  wire logic [VALUE_W-1:0] anchor_value,
   input  wire logic [VALUE_W-1:0] target_value,
   input  wire logic [COUNT_W-1:0] slot_count,
   input  wire logic [INV_W-1:0]   inv_slot_q30,
   input  wire logic               out_ready,
   output logic                    out_push,
   output rsp_item_type            out_item
);

   localparam logic [COUNT_W:0] CAPACITY = (COUNT_W+1)'(SLOT_CAPACITY);

   state_type state_ff, state_in;

   // run state
   logic [VALUE_W-1:0] start_value_ff, start_value_in;
   logic [COUNT_W-1:0] slots_used_ff, slots_used_in;

   // per-item working registers
   logic [VALUE_W-1:0] prev_ff, prev_in;
   logic [VALUE_W-1:0] target_ff, target_in;
   logic [VALUE_W-1:0] inv_ff, inv_in;
   logic [VALUE_W-1:0] alpha_ff, alpha_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] slot_ff, slot_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [VALUE_W-1:0] part_a_ff, part_a_in;

   logic signed [VALUE_W-1:0] op_a, op_b;
   logic signed [PROD_W-1:0]  prod_ff;

   logic [VALUE_W-1:0] prev_sel;
   logic [COUNT_W-1:0] used_sel;
   logic [COUNT_W:0]   used_sum;
   logic               over;
   logic [VALUE_W-1:0] slot_value;

   mcsi_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   assign prev_sel   = first ? anchor_value : start_value_ff;
   assign used_sel   = first ? '0 : slots_used_ff;
   assign used_sum   = {1'b0, used_sel} + {1'b0, slot_count};
   assign over       = used_sum > CAPACITY;
   assign slot_value = part_a_ff + prod_ff[Q_SHIFT +: VALUE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_value_ff <= '0;
         slots_used_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         start_value_ff <= start_value_in;
         slots_used_ff  <= slots_used_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff   <= prev_in;
      target_ff <= target_in;
      inv_ff    <= inv_in;
      alpha_ff  <= alpha_in;
      count_ff  <= count_in;
      slot_ff   <= slot_in;
      idx_ff    <= idx_in;
      part_a_ff <= part_a_in;
   end

   always_comb begin
      state_in       = state_ff;
      start_value_in = start_value_ff;
      slots_used_in  = slots_used_ff;
      prev_in        = prev_ff;
      target_in      = target_ff;
      inv_in         = inv_ff;
      alpha_in       = alpha_ff;
      count_in       = count_ff;
      slot_in        = slot_ff;
      idx_in         = idx_ff;
      part_a_in      = part_a_ff;
      in_ready       = 1'b0;
      out_push       = 1'b0;
      out_item       = '0;
      op_a           = prev_ff;
      op_b           = ONE_Q30 - alpha_ff;

      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (over) begin
                  // rejected: run state untouched, even on first
                  state_in = ST_ERR;
               end else begin
                  start_value_in = target_value;
                  slots_used_in  = used_sum[COUNT_W-1:0];
                  prev_in        = prev_sel;
                  target_in      = target_value;
                  inv_in         = {1'b0, inv_slot_q30};
                  alpha_in       = {1'b0, inv_slot_q30};
                  count_in       = slot_count;
                  slot_in        = COUNT_W'(1);
                  idx_in         = used_sel[INDEX_W-1:0];
                  state_in       = (slot_count == '0) ? ST_IDLE : ST_MUL_A;
               end
            end
         end
         ST_MUL_A: begin
            // prev * (1 - alpha)
            op_a     = prev_ff;
            op_b     = ONE_Q30 - alpha_ff;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            // alpha * target; keep the first term
            op_a      = alpha_ff;
            op_b      = target_ff;
            part_a_in = prod_ff[Q_SHIFT +: VALUE_W];
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // keep the second product in place while the output is stalled
            op_a = alpha_ff;
            op_b = target_ff;
            if (out_ready) begin
               out_push       = 1'b1;
               out_item.value = slot_value;
               out_item.index = idx_ff;
               out_item.last  = (slot_ff == count_ff);
               if (slot_ff == count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + COUNT_W'(1);
                  alpha_in = alpha_ff + inv_ff;
                  idx_in   = idx_ff + INDEX_W'(1);
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_ERR: begin
            if (out_ready) begin
               out_push       = 1'b1;
               out_item.last  = 1'b1;
               out_item.error = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: src/mcsi_chk.sv
// Port-level checker for the slot interpolator, bound to the top level.
// Depends on mcsi_pkg and matrix_coef_slot_interpolator_macros.svh.
`default_nettype none

`include "matrix_coef_slot_interpolator_macros.svh"

module mcsi_chk
   import mcsi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   rsp_tlast,
   input  wire logic                   rsp_tuser
);

   `MCSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // rejected requests give one zero result marked last
   `MCSI_ASSERT_NOW(a_err_shape, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == '0))

   // any request that yields results keeps the block busy the next cycle
   `MCSI_ASSERT_NEXT(a_busy_after, clock, reset, req_tvalid && req_tready && (req_tdata[70:64] != '0), !req_tready)

   `MCSI_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind matrix_coef_slot_interpolator mcsi_chk u_mcsi_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
